// File: rtl/peun_pkg.sv
package peun_pkg;

	// Field widths
	localparam int COORD_WIDTH      = 24;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int OUT_WIDTH        = 16;

	// Datapath widths
	localparam int MAG_W   = COORD_WIDTH + 1;                 // |difference| up to 2^C
	localparam int SQ_W    = 2 * COORD_WIDTH + 1;             // square up to 2^(2C)
	localparam int SUM_W   = SQ_W + 1;
	localparam int ROOT_W  = NORMAL_FRAC_BITS + 2;            // doubled quotient, up to 2^(F+1)
	localparam int Q_W     = NORMAL_FRAC_BITS + 1;            // rounded magnitude, up to 2^F
	localparam int ACC_W   = 2 * COORD_WIDTH + 2 * NORMAL_FRAC_BITS + 5;
	localparam int SCALE_SH = 2 * NORMAL_FRAC_BITS + 2;
	localparam int CNT_W   = $clog2(ROOT_W);
	localparam int NORM_ONE = 1 << NORMAL_FRAC_BITS;

	// Sequencer
	localparam int PC_W = 4;

	localparam logic [PC_W-1:0] ST_WAIT  = PC_W'(0);
	localparam logic [PC_W-1:0] ST_SQA   = PC_W'(1);
	localparam logic [PC_W-1:0] ST_SQB   = PC_W'(2);
	localparam logic [PC_W-1:0] ST_SUM   = PC_W'(3);
	localparam logic [PC_W-1:0] ST_INITX = PC_W'(4);
	localparam logic [PC_W-1:0] ST_ITERX = PC_W'(5);
	localparam logic [PC_W-1:0] ST_SAVEX = PC_W'(6);
	localparam logic [PC_W-1:0] ST_INITY = PC_W'(7);
	localparam logic [PC_W-1:0] ST_ITERY = PC_W'(8);
	localparam logic [PC_W-1:0] ST_SAVEY = PC_W'(9);
	localparam logic [PC_W-1:0] ST_PUSH  = PC_W'(10);
	localparam logic [PC_W-1:0] ST_BACK  = PC_W'(11);

	typedef enum logic [3:0] {
		OP_NOP,
		OP_WAIT,
		OP_SQA,
		OP_SQB,
		OP_SUM,
		OP_INITX,
		OP_INITY,
		OP_ITER,
		OP_SAVEX,
		OP_SAVEY,
		OP_PUSH
	} op_t;

	typedef enum logic [2:0] {
		J_NEXT,
		J_ALWAYS,
		J_IDLE,
		J_ZERO,
		J_MORE,
		J_BUSY
	} jmp_t;

	typedef struct packed {
		op_t             op;
		jmp_t            jmp;
		logic [PC_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		logic init;
		logic step;
	} root_ctrl_t;

	// Control store: jump to target when the condition holds, else step on
	function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
		ucode_t w;
		case (pc)
			ST_WAIT:  w = '{op: OP_WAIT,  jmp: J_IDLE,   target: ST_WAIT};
			ST_SQA:   w = '{op: OP_SQA,   jmp: J_NEXT,   target: ST_WAIT};
			ST_SQB:   w = '{op: OP_SQB,   jmp: J_NEXT,   target: ST_WAIT};
			ST_SUM:   w = '{op: OP_SUM,   jmp: J_ZERO,   target: ST_PUSH};
			ST_INITX: w = '{op: OP_INITX, jmp: J_NEXT,   target: ST_WAIT};
			ST_ITERX: w = '{op: OP_ITER,  jmp: J_MORE,   target: ST_ITERX};
			ST_SAVEX: w = '{op: OP_SAVEX, jmp: J_NEXT,   target: ST_WAIT};
			ST_INITY: w = '{op: OP_INITY, jmp: J_NEXT,   target: ST_WAIT};
			ST_ITERY: w = '{op: OP_ITER,  jmp: J_MORE,   target: ST_ITERY};
			ST_SAVEY: w = '{op: OP_SAVEY, jmp: J_NEXT,   target: ST_WAIT};
			ST_PUSH:  w = '{op: OP_PUSH,  jmp: J_BUSY,   target: ST_PUSH};
			ST_BACK:  w = '{op: OP_NOP,   jmp: J_ALWAYS, target: ST_WAIT};
			default:  w = '{op: OP_NOP,   jmp: J_ALWAYS, target: ST_WAIT};
		endcase
		return w;
	endfunction

endpackage

// File: rtl/peun_root.sv
module peun_root (
	input  logic                         clk,
	input  logic                         arst_n,
	input  peun_pkg::root_ctrl_t         ctrl,
	input  logic [peun_pkg::SQ_W-1:0]    sq,
	input  logic [peun_pkg::SUM_W-1:0]   sum,
	output logic [peun_pkg::Q_W-1:0]     q,
	output logic                         more
);

	// Bit-serial search for the largest m with m^2 * sum <= sq * 2^(2F+2).
	// r_q holds the remainder, u_q = (sum * m) << (k+1), v_q = sum << 2k.
	logic [peun_pkg::ACC_W-1:0]  r_q, u_q, v_q;
	logic [peun_pkg::ROOT_W-1:0] m_q;
	logic [peun_pkg::CNT_W-1:0]  cnt_q;

	logic [peun_pkg::ACC_W-1:0]  trial;
	logic                        take;
	logic [peun_pkg::ROOT_W:0]   m_inc;

	assign trial = u_q + v_q;
	assign take  = (trial <= r_q);
	assign m_inc = {1'b0, m_q} + (peun_pkg::ROOT_W + 1)'(1);
	// round half up on the doubled quotient
	assign q     = m_inc[peun_pkg::Q_W:1];
	assign more  = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.init) begin
			cnt_q <= peun_pkg::CNT_W'(peun_pkg::ROOT_W - 1);
		end else if (ctrl.step) begin
			cnt_q <= cnt_q - peun_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			r_q <= peun_pkg::ACC_W'(sq) << peun_pkg::SCALE_SH;
			v_q <= peun_pkg::ACC_W'(sum) << peun_pkg::SCALE_SH;
			u_q <= '0;
			m_q <= '0;
		end else if (ctrl.step) begin
			if (take) begin
				r_q <= r_q - trial;
				u_q <= (u_q >> 1) + v_q;
			end else begin
				u_q <= u_q >> 1;
			end
			v_q <= v_q >> 2;
			m_q <= {m_q[peun_pkg::ROOT_W-2:0], take};
		end
	end

endmodule

// File: rtl/polyline_edge_unit_normal.sv
// Unit normal of each polyline segment, (y2-y1, x1-x2) / length, 14 fraction bits.
// A point is taken only in the wait step, so a segment is done before the next point is
// accepted; a contour start goes back to the wait step at once. The work is set by
// two 16-step remainder searches that share one accumulator unit; zero length skips them.
// Reset: sequencer to wait step, previous point cleared to zero, no point seen,
// output register empty.
module polyline_edge_unit_normal (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic signed [peun_pkg::COORD_WIDTH-1:0]   point_x,
	input  logic signed [peun_pkg::COORD_WIDTH-1:0]   point_y,
	input  logic                                      contour_start,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic signed [peun_pkg::OUT_WIDTH-1:0]     normal_x,
	output logic signed [peun_pkg::OUT_WIDTH-1:0]     normal_y,
	output logic                                      zero_length
);

	localparam int C = peun_pkg::COORD_WIDTH;

	// Sequencer state
	logic [peun_pkg::PC_W-1:0] pc_q, pc_d;
	peun_pkg::ucode_t          uc;
	logic                      jump;

	// Previous point of the contour
	logic [C-1:0] prev_x_q, prev_y_q;
	logic         have_prev_q;

	// Segment working registers
	logic [peun_pkg::MAG_W-1:0] ax_q, ay_q;
	logic                       sx_q, sy_q;
	logic [peun_pkg::SQ_W-1:0]  a2_q, b2_q;
	logic [peun_pkg::SUM_W-1:0] s_q;
	logic [peun_pkg::OUT_WIDTH-1:0] nx_q, ny_q;
	logic                       zero_q;

	// Output register
	logic                           out_valid_q;
	logic [peun_pkg::OUT_WIDTH-1:0] normal_x_q, normal_y_q;
	logic                           zero_length_q;

	// Datapath nets
	logic                       in_fire, emit, is_zero, out_busy;
	logic signed [C:0]          dx, dy;
	logic [peun_pkg::MAG_W-1:0] mul_a;
	logic [2*peun_pkg::MAG_W-1:0] prod;
	peun_pkg::root_ctrl_t       root_ctrl;
	logic [peun_pkg::SQ_W-1:0]  root_sq;
	logic [peun_pkg::Q_W-1:0]   root_q;
	logic                       root_more;
	logic [peun_pkg::OUT_WIDTH-1:0] q_ext, q_signed;
	logic                       q_neg;

	peun_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (root_ctrl),
		.sq     (root_sq),
		.sum    (s_q),
		.q      (root_q),
		.more   (root_more)
	);

	// Decode the current control word and drive the datapath
	always_comb begin
		uc            = peun_pkg::ucode(pc_q);
		in_ready      = (uc.op == peun_pkg::OP_WAIT);
		in_fire       = in_valid && in_ready;
		// a point without a stored predecessor opens a contour
		emit          = have_prev_q && !contour_start;
		dx            = {point_y[C-1], point_y} - {prev_y_q[C-1], prev_y_q};
		dy            = {prev_x_q[C-1], prev_x_q} - {point_x[C-1], point_x};
		is_zero       = (ax_q == '0) && (ay_q == '0);
		out_busy      = out_valid_q && !out_ready;
		mul_a         = (uc.op == peun_pkg::OP_SQB) ? ay_q : ax_q;
		prod          = mul_a * mul_a;
		root_ctrl.init = (uc.op == peun_pkg::OP_INITX) || (uc.op == peun_pkg::OP_INITY);
		root_ctrl.step = (uc.op == peun_pkg::OP_ITER);
		root_sq       = (uc.op == peun_pkg::OP_INITY) ? b2_q : a2_q;
		// reapply the sign of the component being saved
		q_neg         = (uc.op == peun_pkg::OP_SAVEY) ? sy_q : sx_q;
		q_ext         = peun_pkg::OUT_WIDTH'(root_q);
		q_signed      = q_neg ? (peun_pkg::OUT_WIDTH'(0) - q_ext) : q_ext;
	end

	// Next step: jump on the selected condition, otherwise advance
	always_comb begin
		case (uc.jmp)
			peun_pkg::J_NEXT:   jump = 1'b0;
			peun_pkg::J_ALWAYS: jump = 1'b1;
			peun_pkg::J_IDLE:   jump = !(in_fire && emit);
			peun_pkg::J_ZERO:   jump = is_zero;
			peun_pkg::J_MORE:   jump = root_more;
			peun_pkg::J_BUSY:   jump = out_busy;
			default:            jump = 1'b1;
		endcase
		pc_d = jump ? uc.target : (pc_q + peun_pkg::PC_W'(1));
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= peun_pkg::ST_WAIT;
			have_prev_q <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			// every accepted point becomes the previous point
			if (in_fire) begin
				have_prev_q <= 1'b1;
				prev_x_q    <= point_x;
				prev_y_q    <= point_y;
			end
			// hold the result until the consumer takes it
			if (uc.op == peun_pkg::OP_PUSH && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (uc.op)
			peun_pkg::OP_WAIT: begin
				sx_q <= dx[C];
				sy_q <= dy[C];
				ax_q <= dx[C] ? peun_pkg::MAG_W'(~dx + 1'b1) : peun_pkg::MAG_W'(dx);
				ay_q <= dy[C] ? peun_pkg::MAG_W'(~dy + 1'b1) : peun_pkg::MAG_W'(dy);
			end
			peun_pkg::OP_SQA: begin
				a2_q <= prod[peun_pkg::SQ_W-1:0];
			end
			peun_pkg::OP_SQB: begin
				b2_q <= prod[peun_pkg::SQ_W-1:0];
			end
			peun_pkg::OP_SUM: begin
				s_q    <= peun_pkg::SUM_W'(a2_q) + peun_pkg::SUM_W'(b2_q);
				zero_q <= is_zero;
				nx_q   <= '0;
				ny_q   <= '0;
			end
			peun_pkg::OP_SAVEX: begin
				nx_q <= q_signed;
			end
			peun_pkg::OP_SAVEY: begin
				ny_q <= q_signed;
			end
			peun_pkg::OP_PUSH: begin
				if (!out_busy) begin
					normal_x_q    <= nx_q;
					normal_y_q    <= ny_q;
					zero_length_q <= zero_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign normal_x    = normal_x_q;
	assign normal_y    = normal_y_q;
	assign zero_length = zero_length_q;

	// A zero-length segment carries zero components
	a_zero_comp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_length |-> normal_x == '0 && normal_y == '0)
		else $error("zero-length result with nonzero components");

	// Components stay within the unit range
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_x <= peun_pkg::NORM_ONE && normal_x >= -peun_pkg::NORM_ONE
			&& normal_y <= peun_pkg::NORM_ONE && normal_y >= -peun_pkg::NORM_ONE)
		else $error("normal component outside unit range");

	// A point that closes a segment starts the work, so the input side closes
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && have_prev_q && !contour_start |=> !in_ready)
		else $error("input still open after a segment transfer");

	// A contour start produces no result and leaves the input side open
	a_start_open: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && contour_start |=> in_ready && pc_q == peun_pkg::ST_WAIT)
		else $error("contour start did not return to the wait step");

endmodule

// File: test/polyline_edge_unit_normal_test.sv
module polyline_edge_unit_normal_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  CLK_HALF      = 4;
	localparam int  RESET_CYCLES  = 5;
	localparam int  CYCLE_LIMIT   = 1000000;
	localparam int  DRAIN_CYCLES  = 100;
	localparam int  HOLD_CYCLES   = 600;
	localparam int  PHASE_POINTS  = 375;

	// One unit normal as the block presents it
	typedef struct packed {
		logic signed [peun_pkg::OUT_WIDTH-1:0] nx;
		logic signed [peun_pkg::OUT_WIDTH-1:0] ny;
		logic                                  zero;
	} normal_t;

	logic                                    clk = 1'b0;
	logic                                    arst_n;
	logic                                    in_valid;
	logic                                    in_ready;
	logic signed [peun_pkg::COORD_WIDTH-1:0] point_x;
	logic signed [peun_pkg::COORD_WIDTH-1:0] point_y;
	logic                                    contour_start;
	logic                                    out_valid;
	logic                                    out_ready = 1'b0;
	logic signed [peun_pkg::OUT_WIDTH-1:0]   normal_x;
	logic signed [peun_pkg::OUT_WIDTH-1:0]   normal_y;
	logic                                    zero_length;

	// Shadow of the block's segment state
	logic signed [peun_pkg::COORD_WIDTH-1:0] last_x;
	logic signed [peun_pkg::COORD_WIDTH-1:0] last_y;
	logic                                    have_last;

	normal_t     expected_normals[$];
	int unsigned error_count    = 0;
	int unsigned points_sent    = 0;
	int unsigned normals_seen   = 0;
	int unsigned zero_seen      = 0;
	int unsigned cycle_count    = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_requests  = 0;
	int unsigned hold_served    = 0;
	int unsigned hold_left      = 0;

	polyline_edge_unit_normal i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.point_x       (point_x),
		.point_y       (point_y),
		.contour_start (contour_start),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.normal_x      (normal_x),
		.normal_y      (normal_y),
		.zero_length   (zero_length)
	);

	always #CLK_HALF clk = ~clk;

	// Watchdog: abort a run that hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d normals still pending",
				cycle_count, expected_normals.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Rounded magnitude of |a| * 2^F / sqrt(a^2 + b^2): the largest q in 0..2^F
	// with (2q-1)^2 * (a^2 + b^2) <= a^2 * 2^(2F+2), found by bisection.
	function automatic logic [peun_pkg::Q_W-1:0] unit_magnitude(
		input logic [peun_pkg::MAG_W-1:0] a, input logic [peun_pkg::MAG_W-1:0] b);
		logic [127:0] a_sq;
		logic [127:0] len_sq;
		logic [127:0] odd;
		int unsigned  lo;
		int unsigned  hi;
		int unsigned  mid;
		a_sq   = 128'(a) * 128'(a);
		len_sq = a_sq + 128'(b) * 128'(b);
		lo = 0;
		hi = peun_pkg::NORM_ONE;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			odd = 128'(2 * mid - 1);
			if (odd * odd * len_sq <= (a_sq << peun_pkg::SCALE_SH))
				lo = mid;
			else
				hi = mid - 1;
		end
		return peun_pkg::Q_W'(lo);
	endfunction

	// Advance the shadow state by one accepted point and queue its normal, if any.
	// A point with no earlier point counts as a contour start.
	function automatic void predict_point(input logic signed [peun_pkg::COORD_WIDTH-1:0] x,
		input logic signed [peun_pkg::COORD_WIDTH-1:0] y, input logic start);
		logic signed [peun_pkg::MAG_W-1:0] dx;
		logic signed [peun_pkg::MAG_W-1:0] dy;
		logic [peun_pkg::MAG_W-1:0]        ax;
		logic [peun_pkg::MAG_W-1:0]        ay;
		logic [peun_pkg::Q_W-1:0]          mx;
		logic [peun_pkg::Q_W-1:0]          my;
		normal_t                           n;
		if (have_last && !start) begin
			// Normal of the segment: (y2 - y1, x1 - x2)
			dx = {y[peun_pkg::COORD_WIDTH-1], y}
				- {last_y[peun_pkg::COORD_WIDTH-1], last_y};
			dy = {last_x[peun_pkg::COORD_WIDTH-1], last_x}
				- {x[peun_pkg::COORD_WIDTH-1], x};
			ax = dx[peun_pkg::MAG_W-1] ? -dx : dx;
			ay = dy[peun_pkg::MAG_W-1] ? -dy : dy;
			if (ax == '0 && ay == '0) begin
				n = '{nx: '0, ny: '0, zero: 1'b1};
			end else begin
				mx = unit_magnitude(ax, ay);
				my = unit_magnitude(ay, ax);
				n.nx   = dx[peun_pkg::MAG_W-1] ? -peun_pkg::OUT_WIDTH'(mx)
					: peun_pkg::OUT_WIDTH'(mx);
				n.ny   = dy[peun_pkg::MAG_W-1] ? -peun_pkg::OUT_WIDTH'(my)
					: peun_pkg::OUT_WIDTH'(my);
				n.zero = 1'b0;
			end
			expected_normals.push_back(n);
		end
		last_x    = x;
		last_y    = y;
		have_last = 1'b1;
	endfunction

	// Offer one point, with a random idle gap first, and hold it until the transfer.
	// Inputs change only at the falling edge; in_ready is read at the rising edge.
	task automatic send_point(input logic signed [peun_pkg::COORD_WIDTH-1:0] x,
		input logic signed [peun_pkg::COORD_WIDTH-1:0] y, input logic start);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid      = 1'b1;
		point_x       = x;
		point_y       = y;
		contour_start = start;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_point(x, y, start);
		points_sent++;
	endtask

	// Drop valid after the last transfer of a test
	task automatic release_input();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Wait for every queued normal, then give the block its latency to misbehave
	task automatic drain_results();
		while (expected_normals.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	// The hold-off is counted here, so the sender keeps offering meanwhile.
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_left   = HOLD_CYCLES;
			hold_served = hold_requests;
		end
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else begin
			out_ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each transfer on the output against the oldest queued normal
	always @(posedge clk) begin
		normal_t n;
		if (arst_n && out_valid && out_ready) begin
			if (expected_normals.size() == 0) begin
				$error("unexpected normal: normal_x %0d normal_y %0d zero_length %0d",
					normal_x, normal_y, zero_length);
				error_count++;
			end else begin
				n = expected_normals.pop_front();
				normals_seen++;
				if (n.zero)
					zero_seen++;
				if (normal_x !== n.nx) begin
					$error("normal_x: expected %0d, actual %0d", $signed(n.nx), normal_x);
					error_count++;
				end
				if (normal_y !== n.ny) begin
					$error("normal_y: expected %0d, actual %0d", $signed(n.ny), normal_y);
					error_count++;
				end
				if (zero_length !== n.zero) begin
					$error("zero_length: expected %0d, actual %0d", n.zero, zero_length);
					error_count++;
				end
			end
		end
	end

	// A point without a start flag right after reset opens a contour; then both axes
	task automatic test_first_point();
		send_point(24'sd256, 24'sd512, 1'b0);
		send_point(24'sd512, 24'sd512, 1'b0);
		send_point(24'sd512, 24'sd768, 1'b0);
		release_input();
		drain_results();
	endtask

	// Repeated points give the zero-length flag, also right after a contour start
	task automatic test_zero_length();
		send_point(24'sd512, 24'sd768, 1'b0);
		send_point(-24'sd5, 24'sd7, 1'b1);
		send_point(-24'sd5, 24'sd7, 1'b0);
		release_input();
		drain_results();
	endtask

	// Restart contours between segments and check small and odd slopes
	task automatic test_contour_restart();
		send_point(24'sd1000, 24'sd1000, 1'b1);
		send_point(24'sd1003, 24'sd1004, 1'b0);
		send_point(24'sd0, 24'sd0, 1'b1);
		send_point(24'sd1, 24'sd1, 1'b0);
		send_point(24'sd3, 24'sd2, 1'b0);
		send_point(24'sd3, 24'sd2, 1'b1);
		send_point(-24'sd1, 24'sd2, 1'b0);
		release_input();
		drain_results();
	endtask

	// Corner to corner of the coordinate range: the largest differences possible
	task automatic test_extremes();
		send_point(-24'sd8388608, -24'sd8388608, 1'b1);
		send_point(24'sd8388607, 24'sd8388607, 1'b0);
		send_point(24'sd8388607, -24'sd8388608, 1'b0);
		send_point(-24'sd8388608, 24'sd8388607, 1'b0);
		send_point(-24'sd8388607, 24'sd8388607, 1'b0);
		send_point(24'sd8388607, -24'sd8388607, 1'b0);
		release_input();
		drain_results();
	endtask

	// Hold the output off for a long stretch while points keep coming, so the
	// block fills up and stalls its input
	task automatic test_backpressure();
		@(negedge clk);
		hold_requests++;
		send_point(24'sd20, 24'sd30, 1'b1);
		repeat (9)
			send_point(24'($urandom), 24'($urandom), 1'b0);
		release_input();
		drain_results();
	endtask

	// Move a point by a random step: sizes from one LSB to the full range,
	// with each axis left still now and then
	task automatic step_point(inout logic signed [peun_pkg::COORD_WIDTH-1:0] x,
		inout logic signed [peun_pkg::COORD_WIDTH-1:0] y);
		int unsigned span;
		logic [peun_pkg::COORD_WIDTH-1:0] mask;
		span = $urandom_range(peun_pkg::COORD_WIDTH - 1);
		mask = peun_pkg::COORD_WIDTH'((64'd1 << (span + 1)) - 1);
		if ($urandom_range(99) >= 15)
			x = x + (($urandom_range(1) != 0) ? -(peun_pkg::COORD_WIDTH'($urandom) & mask)
				: (peun_pkg::COORD_WIDTH'($urandom) & mask));
		if ($urandom_range(99) >= 15)
			y = y + (($urandom_range(1) != 0) ? -(peun_pkg::COORD_WIDTH'($urandom) & mask)
				: (peun_pkg::COORD_WIDTH'($urandom) & mask));
	endtask

	// Mostly whole contours with random steps; the rest is stray points,
	// lone starts and repeated points
	task automatic test_random_contours(input int unsigned count,
		input int unsigned send_pct, input int unsigned recv_pct);
		int unsigned sent;
		int unsigned kind;
		logic signed [peun_pkg::COORD_WIDTH-1:0] cx;
		logic signed [peun_pkg::COORD_WIDTH-1:0] cy;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		sent = 0;
		cx = '0;
		cy = '0;
		while (sent < count) begin
			kind = $urandom_range(99);
			if (kind < 85) begin
				cx = peun_pkg::COORD_WIDTH'($urandom);
				cy = peun_pkg::COORD_WIDTH'($urandom);
				send_point(cx, cy, 1'b1);
				sent++;
				repeat ($urandom_range(1, 12)) begin
					step_point(cx, cy);
					send_point(cx, cy, 1'b0);
					sent++;
				end
			end else if (kind < 93) begin
				cx = peun_pkg::COORD_WIDTH'($urandom);
				cy = peun_pkg::COORD_WIDTH'($urandom);
				send_point(cx, cy, 1'($urandom_range(1)));
				sent++;
			end else begin
				send_point(cx, cy, 1'b0);
				sent++;
			end
		end
		release_input();
		drain_results();
	endtask

	initial begin
		// Quiet inputs and reset, released on a falling edge
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		point_x       = '0;
		point_y       = '0;
		contour_start = 1'b0;
		last_x        = '0;
		last_y        = '0;
		have_last     = 1'b0;
		repeat (RESET_CYCLES)
			@(negedge clk);
		arst_n = 1'b1;

		test_first_point();
		test_zero_length();
		test_contour_restart();
		test_extremes();
		test_backpressure();

		// Random contours under each idling pattern
		test_random_contours(PHASE_POINTS, 0, 0);
		test_random_contours(PHASE_POINTS, 63, 0);
		test_random_contours(PHASE_POINTS, 0, 63);
		test_random_contours(PHASE_POINTS, 9, 9);

		$display("Sent %0d points; checked %0d normals, %0d of them zero-length,",
			points_sent, normals_seen, zero_seen);
		$display("across directed corners, a long output hold-off and four idling mixes.");
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
